// ===== sv/lcct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcct_pkg: shared types and constants of the lazy-clear counter table
// Word layouts, operation and status codes, table geometry and the constant
// reciprocal that maps an entry index to its block number.
// ----------------------------------------------------------------------------
`default_nettype none

package lcct_pkg;

  // Table geometry
  localparam int BLOCK_SIZE  = 16;
  localparam int NUM_BLOCKS  = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int CAPACITY    = BLOCK_SIZE * NUM_BLOCKS;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int OFS_W  = $clog2(BLOCK_SIZE);
  localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // Word field widths
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int LIVE_W   = 13;
  localparam int STATUS_W = 2;

  // Block number = (index * BLK_RECIP) >> BLK_SHIFT, exact for 16-bit indexes
  localparam int      BLK_SHIFT = INDEX_W + OFS_W;
  localparam longint  BLK_RECIP = ((64'd1 << BLK_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int      RECIP_W   = BLK_SHIFT + 1;
  localparam int      PROD_W    = INDEX_W + RECIP_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INCR  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DECR  = 2'd2;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT       = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [LIVE_W-1:0]   live_count;
    logic [STATUS_W-1:0] status;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/lcct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcct_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/lazy_clear_counter_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_clear_counter_table_top: counter table with lazy block clear
// Per-entry counters in one RAM, one clean flag per block in flops and a
// live count of nonzero entries. Clear-all zeroes the clean flags and the
// live count only; the first increment into a dirty block zeroes the block in RAM.
//
//   channel   ports                      handshake
//   input     in_word (func, index)      taken when start=1 and busy=0
//   result    out_word (value, live,     out_valid strobe, one cycle,
//             status)                    no back-pressure
//
// Read, increment and decrement of an entry in a clean block pass through
// S_RMW: the counter RAM read, then modify and write back.
// Clear-all, out-of-range indexes and read/decrement of a dirty block are
// answered from S_IDLE and never write the RAM.
// Increment into a dirty block sweeps the block in S_SWEEP, one RAM entry
// per cycle, writing 1 to the target entry and 0 to the rest.
// After reset every block is dirty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_clear_counter_table_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lcct_pkg::in_word_t in_word,
  output logic                    out_valid,
  output lcct_pkg::out_word_t     out_word
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SWEEP
  } state_t;

  state_t                             state_r;
  logic [lcct_pkg::NUM_BLOCKS-1:0]    clean_r;
  logic [lcct_pkg::LIVE_W-1:0]        live_r;
  logic [lcct_pkg::FUNC_W-1:0]        func_r;
  logic [lcct_pkg::ADDR_W-1:0]        addr_r;
  logic [lcct_pkg::BLK_W-1:0]         blk_r;
  logic [lcct_pkg::OFS_W-1:0]         sweep_cnt_r;
  logic                               out_valid_r;
  lcct_pkg::out_word_t                out_r;

  logic                               accept;
  logic                               in_range;
  logic [lcct_pkg::PROD_W-1:0]        blk_prod;
  logic [lcct_pkg::BLK_W-1:0]         blk;
  logic                               blk_clean;

  logic                               ram_we;
  logic [lcct_pkg::ADDR_W-1:0]        ram_waddr;
  logic [lcct_pkg::COUNT_WIDTH-1:0]   ram_wdata;
  logic [lcct_pkg::ADDR_W-1:0]        ram_raddr;
  logic [lcct_pkg::COUNT_WIDTH-1:0]   ram_rdata;

  logic                               cnt_zero;
  logic                               cnt_max;
  logic [lcct_pkg::COUNT_WIDTH-1:0]   cnt_inc;
  logic [lcct_pkg::COUNT_WIDTH-1:0]   cnt_dec;
  logic [lcct_pkg::LIVE_W-1:0]        rmw_live;
  lcct_pkg::out_word_t                rmw_out;
  logic                               rmw_write;
  logic [lcct_pkg::COUNT_WIDTH-1:0]   rmw_wdata;

  logic [lcct_pkg::ADDR_W-1:0]        sweep_addr;
  logic                               sweep_last;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // decode the incoming word: range check and block number by reciprocal
  always_comb begin
    in_range  = 32'(in_word.index) < 32'(lcct_pkg::CAPACITY);
    blk_prod  = lcct_pkg::PROD_W'(in_word.index) *
                lcct_pkg::PROD_W'(lcct_pkg::BLK_RECIP);
    blk       = lcct_pkg::BLK_W'(blk_prod >> lcct_pkg::BLK_SHIFT);
    blk_clean = in_range ? clean_r[blk] : 1'b0;
    ram_raddr = lcct_pkg::ADDR_W'(in_word.index);
  end

  // modify the counter read back from RAM
  always_comb begin
    cnt_zero  = (ram_rdata == '0);
    cnt_max   = (ram_rdata == '1);
    cnt_inc   = ram_rdata + lcct_pkg::COUNT_WIDTH'(1);
    cnt_dec   = ram_rdata - lcct_pkg::COUNT_WIDTH'(1);
    rmw_live  = live_r;
    rmw_write = 1'b0;
    rmw_wdata = cnt_inc;
    rmw_out.value      = '0;
    rmw_out.status     = lcct_pkg::ST_OK;
    case (func_r)
      lcct_pkg::OP_READ: begin
        rmw_out.value = lcct_pkg::VALUE_W'(ram_rdata);
      end
      lcct_pkg::OP_INCR: begin
        if (cnt_max) begin
          rmw_out.value  = lcct_pkg::VALUE_W'(ram_rdata);
          rmw_out.status = lcct_pkg::ST_SAT;
        end else begin
          rmw_write     = 1'b1;
          rmw_wdata     = cnt_inc;
          rmw_out.value = lcct_pkg::VALUE_W'(cnt_inc);
          if (cnt_zero) begin
            rmw_live = live_r + lcct_pkg::LIVE_W'(1);
          end
        end
      end
      lcct_pkg::OP_DECR: begin
        if (cnt_zero) begin
          rmw_out.status = lcct_pkg::ST_UNDERFLOW;
        end else begin
          rmw_write     = 1'b1;
          rmw_wdata     = cnt_dec;
          rmw_out.value = lcct_pkg::VALUE_W'(cnt_dec);
          if (cnt_dec == '0 && live_r != '0) begin
            rmw_live = live_r - lcct_pkg::LIVE_W'(1);
          end
        end
      end
      default: begin
        rmw_out.value = '0;
      end
    endcase
    rmw_out.live_count = rmw_live;
  end

  // sweep address walks the dirty block; the target entry gets one
  always_comb begin
    sweep_addr = lcct_pkg::ADDR_W'(blk_r * lcct_pkg::BLOCK_SIZE) +
                 lcct_pkg::ADDR_W'(sweep_cnt_r);
    sweep_last = (sweep_cnt_r == lcct_pkg::OFS_W'(lcct_pkg::BLOCK_SIZE - 1));
  end

  // select the RAM write source
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = rmw_wdata;
    case (state_r)
      S_RMW: begin
        ram_we    = rmw_write;
        ram_waddr = addr_r;
        ram_wdata = rmw_wdata;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = (sweep_addr == addr_r) ? lcct_pkg::COUNT_WIDTH'(1) : '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lcct_ram #(
    .WIDTH (lcct_pkg::COUNT_WIDTH),
    .DEPTH (lcct_pkg::CAPACITY)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequence operations, hold table state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clean_r     <= '0;
      live_r      <= '0;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r      <= in_word.func;
            addr_r      <= ram_raddr;
            blk_r       <= blk;
            sweep_cnt_r <= '0;
            out_r.value      <= '0;
            out_r.live_count <= live_r;
            out_r.status     <= lcct_pkg::ST_OK;
            if (in_word.func == lcct_pkg::OP_CLEAR) begin
              clean_r          <= '0;
              live_r           <= '0;
              out_r.live_count <= '0;
              out_valid_r      <= 1'b1;
            end else if (!in_range) begin
              out_r.status <= lcct_pkg::ST_RANGE;
              out_valid_r  <= 1'b1;
            end else if (!blk_clean) begin
              case (in_word.func)
                lcct_pkg::OP_INCR: begin
                  state_r <= S_SWEEP;
                end
                lcct_pkg::OP_DECR: begin
                  out_r.status <= lcct_pkg::ST_UNDERFLOW;
                  out_valid_r  <= 1'b1;
                end
                default: begin
                  out_valid_r <= 1'b1;
                end
              endcase
            end else begin
              state_r <= S_RMW;
            end
          end
        end
        S_RMW: begin
          live_r      <= rmw_live;
          out_r       <= rmw_out;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_SWEEP: begin
          sweep_cnt_r <= sweep_cnt_r + lcct_pkg::OFS_W'(1);
          if (sweep_last) begin
            clean_r[blk_r]   <= 1'b1;
            live_r           <= live_r + lcct_pkg::LIVE_W'(1);
            out_r.value      <= lcct_pkg::VALUE_W'(1);
            out_r.live_count <= live_r + lcct_pkg::LIVE_W'(1);
            out_r.status     <= lcct_pkg::ST_OK;
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
